@@ rtl/w2dh_pkg.sv @@
// Shared types, constants and codes of the weighted 2-D histogram.
package w2dh_pkg;

  // Bin store geometry
  localparam int MAX_X_BINS = 64;
  localparam int MAX_Y_BINS = 64;
  localparam int X_IDX_W    = $clog2(MAX_X_BINS);
  localparam int Y_IDX_W    = $clog2(MAX_Y_BINS);
  localparam int BIN_DEPTH  = MAX_X_BINS * MAX_Y_BINS;
  localparam int ADDR_W     = $clog2(BIN_DEPTH);
  localparam int DIV_Q_W    = (X_IDX_W > Y_IDX_W) ? X_IDX_W : Y_IDX_W;

  // Field widths
  localparam int COORD_W    = 24;
  localparam int WIDTH_W    = 23;
  localparam int COUNT_W    = 7;
  localparam int VALUE_W    = 32;
  localparam int FIELD_IDX_W = 6;
  localparam int DIVIDEND_W = COORD_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic signed [COORD_W-1:0] LOW_RST   = 24'sd0;
  localparam logic signed [COORD_W-1:0] HIGH_RST  = 24'sd8388607;
  localparam logic [WIDTH_W-1:0]        WIDTH_RST = 23'd131072;
  localparam logic [COUNT_W-1:0]        COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_LOW   = 3'd0,
    CFG_X_HIGH  = 3'd1,
    CFG_X_WIDTH = 3'd2,
    CFG_X_COUNT = 3'd3,
    CFG_Y_LOW   = 3'd4,
    CFG_Y_HIGH  = 3'd5,
    CFG_Y_WIDTH = 3'd6,
    CFG_Y_COUNT = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_XSTART,
    S_XWAIT,
    S_YWAIT,
    S_MERGE,
    S_DIRECT,
    S_FINISH
  } state_e;

  // Command word
  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] sample_x;
    logic signed [COORD_W-1:0] sample_y;
    logic signed [VALUE_W-1:0] sample_weight;
    logic [FIELD_IDX_W-1:0]    bin_col;
    logic [FIELD_IDX_W-1:0]    bin_row;
    logic signed [VALUE_W-1:0] new_content;
  } hist_in_t;

  // Result word
  typedef struct packed {
    logic signed [VALUE_W-1:0] read_content;
    logic                      landed;
    logic signed [VALUE_W-1:0] missed_sum;
  } hist_out_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [DIV_Q_W-1:0] quot;
  } div_res_t;

endpackage

@@ rtl/w2dh_ram.sv @@
// Generic simple dual-port RAM with registered read.
module w2dh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/w2dh_div.sv @@
// Restoring divider: one quotient bit per cycle, with an overflow test first.
module w2dh_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [w2dh_pkg::DIVIDEND_W-1:0]     dividend_i,
  input  logic [w2dh_pkg::WIDTH_W-1:0]        divisor_i,
  output w2dh_pkg::div_res_t                  res_o
);

  localparam int DV_W  = w2dh_pkg::WIDTH_W + w2dh_pkg::DIV_Q_W;
  localparam int CMP_W = (DV_W > w2dh_pkg::DIVIDEND_W) ? DV_W : w2dh_pkg::DIVIDEND_W;
  localparam int CNT_W = $clog2(w2dh_pkg::DIV_Q_W + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(w2dh_pkg::DIV_Q_W);

  logic                              busy_q;
  logic                              done_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic [w2dh_pkg::DIVIDEND_W-1:0]   rem_q;
  logic [DV_W-1:0]                   dv_q;
  logic [w2dh_pkg::DIV_Q_W-1:0]      quot_q;
  logic                              ovf_q;
  logic                              ge;

  // Trial compare against the shifted divisor
  assign ge = CMP_W'(rem_q) >= CMP_W'(dv_q);

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: step 0 tests for a quotient that does not fit, then one bit a step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dv_q   <= {divisor_i, {w2dh_pkg::DIV_Q_W{1'b0}}};
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        ovf_q <= ge;
      end else if (ge) begin
        rem_q  <= rem_q - w2dh_pkg::DIVIDEND_W'(dv_q);
        quot_q <= {quot_q[w2dh_pkg::DIV_Q_W-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[w2dh_pkg::DIV_Q_W-2:0], 1'b0};
      end
      dv_q <= dv_q >> 1;
    end
  end

  assign res_o.done = done_q;
  assign res_o.ovf  = ovf_q;
  assign res_o.quot = quot_q;

endmodule

@@ rtl/weighted_2d_histogram_core.sv @@
// Top level of the weighted 2-D histogram: registers, sequencer, bin store.
//
// Usage: configuration registers are written through cfg_we_i / cfg_idx_i /
// cfg_data_i at any edge with no wait; write them only while the block is idle.
// A command word on cmd_i is taken at an edge where start_i is high and busy_o
// is low. Each command gives one result word on res_o, marked by done_o for
// exactly one cycle; the receiver must take it then and cannot stall it.
// A write, read or unused op passes through the direct and finish states.
// busy_o falls in the done_o cycle, so a new command can be taken there. An
// add runs the coordinate quotients for x and then y through the one shared
// restoring divider (one overflow step plus six quotient bits, then a
// registered done status each), then a read-modify-write of the bin store RAM,
// or of the missed total when the sample misses. After reset the bin store is
// cleared by a pass over every bin, one bin a cycle, with busy_o high;
// configuration writes are taken meanwhile. Registers and the missed total
// come out of reset at once.
module weighted_2d_histogram_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [w2dh_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [w2dh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                start_i,
  input  w2dh_pkg::hist_in_t                  cmd_i,
  output logic                                busy_o,
  output logic                                done_o,
  output w2dh_pkg::hist_out_t                 res_o
);

  localparam int AW = w2dh_pkg::ADDR_W;
  localparam int VW = w2dh_pkg::VALUE_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(w2dh_pkg::BIN_DEPTH - 1);

  // Saturating signed add
  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a, input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      return s[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end
    return s[VW-1:0];
  endfunction

  w2dh_pkg::state_e state_q, state_d;

  logic signed [w2dh_pkg::COORD_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic [w2dh_pkg::WIDTH_W-1:0]        x_width_q, y_width_q;
  logic [w2dh_pkg::COUNT_W-1:0]        x_count_q, y_count_q;

  w2dh_pkg::hist_in_t   cmd_q;
  w2dh_pkg::hist_out_t  res_q;
  logic                 done_q;
  logic [AW-1:0]        clr_q;
  logic [VW-1:0]        missed_q;
  logic                 hx_q, hy_q;
  logic [w2dh_pkg::X_IDX_W-1:0] ix_q;
  logic [AW-1:0]        add_addr_q;

  // Divider hookup
  logic                                div_start;
  logic                                sel_y;
  logic [w2dh_pkg::DIVIDEND_W-1:0]     div_dividend;
  logic [w2dh_pkg::WIDTH_W-1:0]        div_divisor;
  w2dh_pkg::div_res_t                  div_res;

  // RAM hookup
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0] ram_wdata, ram_rdata;

  // Datapath helpers
  logic [w2dh_pkg::DIVIDEND_W-1:0] x_diff, y_diff;
  logic          x_hit, y_hit;
  logic          landed;
  logic [VW-1:0] sum;
  logic          direct_ok;
  logic [AW-1:0] direct_addr, add_addr;

  assign x_diff = w2dh_pkg::DIVIDEND_W'(cmd_q.sample_x) - w2dh_pkg::DIVIDEND_W'(x_low_q);
  assign y_diff = w2dh_pkg::DIVIDEND_W'(cmd_q.sample_y) - w2dh_pkg::DIVIDEND_W'(y_low_q);

  // Coordinate falls in a bin in use (valid while the divider reports done)
  assign x_hit = (cmd_q.sample_x >= x_low_q) && (cmd_q.sample_x <= x_high_q) &&
                 (x_width_q != '0) && !div_res.ovf &&
                 (int'(div_res.quot) < int'(x_count_q)) &&
                 (int'(div_res.quot) < w2dh_pkg::MAX_X_BINS);
  assign y_hit = (cmd_q.sample_y >= y_low_q) && (cmd_q.sample_y <= y_high_q) &&
                 (y_width_q != '0) && !div_res.ovf &&
                 (int'(div_res.quot) < int'(y_count_q)) &&
                 (int'(div_res.quot) < w2dh_pkg::MAX_Y_BINS);

  assign add_addr = AW'(ix_q) * AW'(w2dh_pkg::MAX_Y_BINS)
                  + AW'(div_res.quot[w2dh_pkg::Y_IDX_W-1:0]);
  assign direct_addr = AW'(cmd_q.bin_col) * AW'(w2dh_pkg::MAX_Y_BINS) + AW'(cmd_q.bin_row);
  assign direct_ok = (int'(cmd_q.bin_col) < w2dh_pkg::MAX_X_BINS) &&
                     (int'(cmd_q.bin_row) < w2dh_pkg::MAX_Y_BINS);

  // One saturating adder serves the bin and the missed total
  assign landed = hx_q && hy_q;
  assign sum    = sat_add(landed ? ram_rdata : missed_q, cmd_q.sample_weight);

  // Divider operands: x in the start state, y when the x quotient comes back
  assign sel_y        = (state_q == w2dh_pkg::S_XWAIT);
  assign div_dividend = sel_y ? y_diff : x_diff;
  assign div_divisor  = sel_y ? y_width_q : x_width_q;

  w2dh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .res_o      (div_res)
  );

  w2dh_ram #(
    .WIDTH (VW),
    .DEPTH (w2dh_pkg::BIN_DEPTH)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      w2dh_pkg::S_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = w2dh_pkg::S_IDLE;
      end
      w2dh_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = (cmd_i.op == w2dh_pkg::OP_ADD) ? w2dh_pkg::S_XSTART : w2dh_pkg::S_DIRECT;
        end
      end
      w2dh_pkg::S_XSTART: state_d = w2dh_pkg::S_XWAIT;
      w2dh_pkg::S_XWAIT: begin
        if (div_res.done) state_d = w2dh_pkg::S_YWAIT;
      end
      w2dh_pkg::S_YWAIT: begin
        if (div_res.done) state_d = w2dh_pkg::S_MERGE;
      end
      w2dh_pkg::S_MERGE:  state_d = w2dh_pkg::S_IDLE;
      w2dh_pkg::S_DIRECT: state_d = w2dh_pkg::S_FINISH;
      w2dh_pkg::S_FINISH: state_d = w2dh_pkg::S_IDLE;
      default:            state_d = w2dh_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    div_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = add_addr_q;
    ram_wdata = sum;
    ram_raddr = direct_addr;
    unique case (state_q)
      w2dh_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      w2dh_pkg::S_XSTART: div_start = 1'b1;
      w2dh_pkg::S_XWAIT:  div_start = div_res.done;
      w2dh_pkg::S_YWAIT:  ram_raddr = add_addr;
      w2dh_pkg::S_MERGE:  ram_we = landed;
      w2dh_pkg::S_DIRECT: begin
        ram_we    = (cmd_q.op == w2dh_pkg::OP_WRITE) && direct_ok;
        ram_waddr = direct_addr;
        ram_wdata = cmd_q.new_content;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= w2dh_pkg::S_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      missed_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == w2dh_pkg::S_MERGE) || (state_q == w2dh_pkg::S_FINISH);
      if (state_q == w2dh_pkg::S_CLEAR) clr_q <= clr_q + AW'(1);
      if ((state_q == w2dh_pkg::S_MERGE) && !landed) missed_q <= sum;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q   <= w2dh_pkg::LOW_RST;
      x_high_q  <= w2dh_pkg::HIGH_RST;
      x_width_q <= w2dh_pkg::WIDTH_RST;
      x_count_q <= w2dh_pkg::COUNT_RST;
      y_low_q   <= w2dh_pkg::LOW_RST;
      y_high_q  <= w2dh_pkg::HIGH_RST;
      y_width_q <= w2dh_pkg::WIDTH_RST;
      y_count_q <= w2dh_pkg::COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        w2dh_pkg::CFG_X_LOW:   x_low_q   <= cfg_data_i;
        w2dh_pkg::CFG_X_HIGH:  x_high_q  <= cfg_data_i;
        w2dh_pkg::CFG_X_WIDTH: x_width_q <= cfg_data_i[w2dh_pkg::WIDTH_W-1:0];
        w2dh_pkg::CFG_X_COUNT: x_count_q <= cfg_data_i[w2dh_pkg::COUNT_W-1:0];
        w2dh_pkg::CFG_Y_LOW:   y_low_q   <= cfg_data_i;
        w2dh_pkg::CFG_Y_HIGH:  y_high_q  <= cfg_data_i;
        w2dh_pkg::CFG_Y_WIDTH: y_width_q <= cfg_data_i[w2dh_pkg::WIDTH_W-1:0];
        w2dh_pkg::CFG_Y_COUNT: y_count_q <= cfg_data_i[w2dh_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Command capture, bin indices and result word
  always_ff @(posedge clk_i) begin
    if ((state_q == w2dh_pkg::S_IDLE) && start_i) cmd_q <= cmd_i;
    if ((state_q == w2dh_pkg::S_XWAIT) && div_res.done) begin
      hx_q <= x_hit;
      ix_q <= div_res.quot[w2dh_pkg::X_IDX_W-1:0];
    end
    if ((state_q == w2dh_pkg::S_YWAIT) && div_res.done) begin
      hy_q       <= y_hit;
      add_addr_q <= add_addr;
    end
    if (state_q == w2dh_pkg::S_MERGE) begin
      res_q.read_content <= '0;
      res_q.landed       <= landed;
      res_q.missed_sum   <= landed ? missed_q : sum;
    end
    if (state_q == w2dh_pkg::S_FINISH) begin
      res_q.read_content <= ((cmd_q.op == w2dh_pkg::OP_READ) && direct_ok) ? ram_rdata : '0;
      res_q.landed       <= 1'b0;
      res_q.missed_sum   <= missed_q;
    end
  end

  assign busy_o = (state_q != w2dh_pkg::S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTH
  // A result only follows the merge or finish step
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == w2dh_pkg::S_MERGE || state_q == w2dh_pkg::S_FINISH))
    else $error("result strobe without a finishing step");

  // An accepted command keeps the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted command did not raise busy");

  // Divider reports only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == w2dh_pkg::S_XWAIT || state_q == w2dh_pkg::S_YWAIT))
    else $error("divider finished outside a wait state");

  // Reported missed sum matches the running total
  a_missed_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.missed_sum == missed_q))
    else $error("missed sum out of step with the running total");
`endif

endmodule
